@@ rtl/sit_pkg.sv @@
// sit_pkg: widths, queue sizing, the queue entry type and sub_ext for the segment
// intersection test. No dependencies; all rtl files but sit_checker refer to it by name.
package sit_pkg;

  localparam int COORD_WIDTH = 24;                 // Q15.8 coordinate
  localparam int DW          = COORD_WIDTH + 1;    // coordinate difference
  localparam int PW          = 2 * DW;             // product of two differences
  localparam int SW          = PW + 2;             // sums and differences of products
  localparam int RW          = DW;                 // integer square root of a squared length
  localparam int TOL_W       = 16;                 // tolerance register
  localparam int SLW         = TOL_W + RW;         // tolerance times length
  localparam int LANES       = 4;                  // orientation / projection checks
  localparam int Q_DEPTH     = 4;
  localparam int Q_AW        = $clog2(Q_DEPTH);
  localparam int Q_CW        = $clog2(Q_DEPTH + 1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // One classified segment pair, handed from front to back.
  typedef struct packed {
    logic                       hit_x;    // proper crossing seen by orientations
    logic [LANES-1:0]           coll;     // collinear end point, nonzero reference length
    logic                       use_tol;
    logic [1:0][PW-1:0]         l2;       // squared lengths of A and B
    logic [LANES-1:0][SW-1:0]   s;        // projection dot products
    logic [LANES-1:0][SW-1:0]   h;        // squared length minus dot product
  } entry_t;

  function automatic logic signed [DW-1:0] sub_ext(input coord_t a, input coord_t b);
    sub_ext = DW'(a) - DW'(b);
  endfunction

endpackage

@@ rtl/segment_intersection_test.sv @@
// segment_intersection_test: top level of the segment intersection test.
// Depends on sit_pkg, sit_front, sit_queue and sit_back.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_stall     in_a_*, in_b_* (Q15.8), in_use_tolerance
//   out      output     out_valid / out_stall   out_intersects
//   cfg      input      cfg_valid / cfg_ready   cfg_data (tolerance, 1/256 units)
//
// One segment pair per cycle sustained while neither side stalls; each beat passes
// 32 register stages: 3 front stages, the queue write, the back's entry register,
// 25 square-root stages (one result bit each), the slack multiply and the output
// register.
// Reset is synchronous, active low; it empties all stages and the queue and
// clears tolerance to zero. cfg_ready is always high.
// Front and back stall on their own: the front stalls only when its last stage
// holds a beat and the 4-deep queue is full and not being drained; the back
// advances whenever the output register is empty or its beat is taken.
module segment_intersection_test (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  sit_pkg::coord_t             in_a_start_x,
  input  sit_pkg::coord_t             in_a_start_y,
  input  sit_pkg::coord_t             in_a_end_x,
  input  sit_pkg::coord_t             in_a_end_y,
  input  sit_pkg::coord_t             in_b_start_x,
  input  sit_pkg::coord_t             in_b_start_y,
  input  sit_pkg::coord_t             in_b_end_x,
  input  sit_pkg::coord_t             in_b_end_y,
  input  logic                        in_use_tolerance,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_intersects,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sit_pkg::TOL_W-1:0]   cfg_data
);

  logic [sit_pkg::TOL_W-1:0] tol_r;
  sit_pkg::entry_t           wr_entry;
  sit_pkg::entry_t           rd_entry;
  logic                      push;
  logic                      pop;
  logic                      not_empty;
  logic                      full;
  logic                      q_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      tol_r <= cfg_data;
    end
  end

  // a slot frees up in the same cycle as a pop
  assign q_ready = !full || pop;

  sit_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .a_start_x     (in_a_start_x),
    .a_start_y     (in_a_start_y),
    .a_end_x       (in_a_end_x),
    .a_end_y       (in_a_end_y),
    .b_start_x     (in_b_start_x),
    .b_start_y     (in_b_start_y),
    .b_end_x       (in_b_end_x),
    .b_end_y       (in_b_end_y),
    .use_tolerance (in_use_tolerance),
    .q_ready       (q_ready),
    .push          (push),
    .entry         (wr_entry)
  );

  sit_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_entry  (wr_entry),
    .pop       (pop),
    .rd_entry  (rd_entry),
    .not_empty (not_empty),
    .full      (full)
  );

  sit_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .tol            (tol_r),
    .head           (rd_entry),
    .head_valid     (not_empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_intersects (out_intersects)
  );

endmodule

@@ rtl/sit_front.sv @@
// sit_front: accepts segment pairs, forms differences, products and sums,
// and classifies each pair into a queue entry. Uses sit_pkg.
module sit_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  sit_pkg::coord_t        a_start_x,
  input  sit_pkg::coord_t        a_start_y,
  input  sit_pkg::coord_t        a_end_x,
  input  sit_pkg::coord_t        a_end_y,
  input  sit_pkg::coord_t        b_start_x,
  input  sit_pkg::coord_t        b_start_y,
  input  sit_pkg::coord_t        b_end_x,
  input  sit_pkg::coord_t        b_end_y,
  input  logic                   use_tolerance,
  input  logic                   q_ready,
  output logic                   push,
  output sit_pkg::entry_t        entry
);

  localparam int NV = 10;
  // difference vector slots
  localparam int D_A    = 0;  // a_end - a_start
  localparam int D_B    = 1;  // b_end - b_start
  localparam int D_B0A1 = 2;
  localparam int D_B1A1 = 3;
  localparam int D_A0B1 = 4;
  localparam int D_A1B1 = 5;
  localparam int D_B0A0 = 6;
  localparam int D_B1A0 = 7;
  localparam int D_A0B0 = 8;
  localparam int D_A1B0 = 9;

  localparam int CR_REF [sit_pkg::LANES] = '{D_A, D_A, D_B, D_B};
  localparam int CR_OTH [sit_pkg::LANES] = '{D_B0A1, D_B1A1, D_A0B1, D_A1B1};
  localparam int DT_OTH [sit_pkg::LANES] = '{D_B0A0, D_B1A0, D_A0B0, D_A1B0};

  localparam logic [1:0] ORI_COL = 2'd0;
  localparam logic [1:0] ORI_POS = 2'd1;
  localparam logic [1:0] ORI_NEG = 2'd2;

  logic                           fe;
  logic [2:0]                     f_vld_r;
  logic [2:0]                     ut_r;
  logic signed [sit_pkg::DW-1:0]  dx_r [NV];
  logic signed [sit_pkg::DW-1:0]  dy_r [NV];
  logic signed [sit_pkg::PW-1:0]  cp_r [sit_pkg::LANES][2];
  logic signed [sit_pkg::PW-1:0]  dp_r [sit_pkg::LANES][2];
  logic signed [sit_pkg::PW-1:0]  lp_r [2][2];
  logic signed [sit_pkg::SW-1:0]  cr_r [sit_pkg::LANES];
  logic signed [sit_pkg::SW-1:0]  dt_r [sit_pkg::LANES];
  logic signed [sit_pkg::SW-1:0]  l2_r [2];
  logic [1:0]                     ori  [sit_pkg::LANES];

  assign fe       = !f_vld_r[2] || q_ready;
  assign in_stall = !fe;
  assign push     = f_vld_r[2] && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= '0;
    end else if (fe) begin
      f_vld_r <= {f_vld_r[1:0], in_valid};
    end
  end

  // stage 1: differences
  always_ff @(posedge clk) begin
    if (fe) begin
      ut_r          <= {ut_r[1:0], use_tolerance};
      dx_r[D_A]    <= sit_pkg::sub_ext(a_end_x,   a_start_x);
      dy_r[D_A]    <= sit_pkg::sub_ext(a_end_y,   a_start_y);
      dx_r[D_B]    <= sit_pkg::sub_ext(b_end_x,   b_start_x);
      dy_r[D_B]    <= sit_pkg::sub_ext(b_end_y,   b_start_y);
      dx_r[D_B0A1] <= sit_pkg::sub_ext(b_start_x, a_end_x);
      dy_r[D_B0A1] <= sit_pkg::sub_ext(b_start_y, a_end_y);
      dx_r[D_B1A1] <= sit_pkg::sub_ext(b_end_x,   a_end_x);
      dy_r[D_B1A1] <= sit_pkg::sub_ext(b_end_y,   a_end_y);
      dx_r[D_A0B1] <= sit_pkg::sub_ext(a_start_x, b_end_x);
      dy_r[D_A0B1] <= sit_pkg::sub_ext(a_start_y, b_end_y);
      dx_r[D_A1B1] <= sit_pkg::sub_ext(a_end_x,   b_end_x);
      dy_r[D_A1B1] <= sit_pkg::sub_ext(a_end_y,   b_end_y);
      dx_r[D_B0A0] <= sit_pkg::sub_ext(b_start_x, a_start_x);
      dy_r[D_B0A0] <= sit_pkg::sub_ext(b_start_y, a_start_y);
      dx_r[D_B1A0] <= sit_pkg::sub_ext(b_end_x,   a_start_x);
      dy_r[D_B1A0] <= sit_pkg::sub_ext(b_end_y,   a_start_y);
      dx_r[D_A0B0] <= sit_pkg::sub_ext(a_start_x, b_start_x);
      dy_r[D_A0B0] <= sit_pkg::sub_ext(a_start_y, b_start_y);
      dx_r[D_A1B0] <= sit_pkg::sub_ext(a_end_x,   b_start_x);
      dy_r[D_A1B0] <= sit_pkg::sub_ext(a_end_y,   b_start_y);
    end
  end

  // stage 2: products; stage 3: sums
  always_ff @(posedge clk) begin
    if (fe) begin
      for (int i = 0; i < sit_pkg::LANES; i++) begin
        cp_r[i][0] <= dy_r[CR_REF[i]] * dx_r[CR_OTH[i]];
        cp_r[i][1] <= dx_r[CR_REF[i]] * dy_r[CR_OTH[i]];
        dp_r[i][0] <= dx_r[DT_OTH[i]] * dx_r[CR_REF[i]];
        dp_r[i][1] <= dy_r[DT_OTH[i]] * dy_r[CR_REF[i]];
        cr_r[i]    <= sit_pkg::SW'(cp_r[i][0]) - sit_pkg::SW'(cp_r[i][1]);
        dt_r[i]    <= sit_pkg::SW'(dp_r[i][0]) + sit_pkg::SW'(dp_r[i][1]);
      end
      for (int j = 0; j < 2; j++) begin
        lp_r[j][0] <= dx_r[j] * dx_r[j];
        lp_r[j][1] <= dy_r[j] * dy_r[j];
        l2_r[j]    <= sit_pkg::SW'(lp_r[j][0]) + sit_pkg::SW'(lp_r[j][1]);
      end
    end
  end

  // classification into a queue entry
  always_comb begin
    entry = '0;
    for (int i = 0; i < sit_pkg::LANES; i++) begin
      if (cr_r[i] == '0) begin
        ori[i] = ORI_COL;
      end else if (cr_r[i][sit_pkg::SW-1]) begin
        ori[i] = ORI_NEG;
      end else begin
        ori[i] = ORI_POS;
      end
      entry.coll[i] = (ori[i] == ORI_COL) && (l2_r[i / 2] != '0);
      entry.s[i]    = dt_r[i];
      entry.h[i]    = l2_r[i / 2] - dt_r[i];
    end
    entry.hit_x   = (ori[0] != ori[1]) && (ori[2] != ori[3]);
    entry.use_tol = ut_r[2];
    entry.l2[0]   = l2_r[0][sit_pkg::PW-1:0];
    entry.l2[1]   = l2_r[1][sit_pkg::PW-1:0];
  end

endmodule

@@ rtl/sit_queue.sv @@
// sit_queue: short register queue of classified entries between front and back.
// Uses sit_pkg for the entry type and depth.
module sit_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sit_pkg::entry_t  wr_entry,
  input  logic             pop,
  output sit_pkg::entry_t  rd_entry,
  output logic             not_empty,
  output logic             full
);

  sit_pkg::entry_t           mem_r [sit_pkg::Q_DEPTH];
  logic [sit_pkg::Q_AW-1:0]  wp_r;
  logic [sit_pkg::Q_AW-1:0]  rp_r;
  logic [sit_pkg::Q_CW-1:0]  cnt_r;
  logic [sit_pkg::Q_CW-1:0]  cnt_nxt;

  assign rd_entry  = mem_r[rp_r];
  assign not_empty = cnt_r != '0;
  assign full      = cnt_r == sit_pkg::Q_CW'(sit_pkg::Q_DEPTH);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_entry;
    end
  end

endmodule

@@ rtl/sit_back.sv @@
// sit_back: pipelined integer square roots of both squared lengths, tolerance
// slack product, projection checks and the output register. Uses sit_pkg.
module sit_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [sit_pkg::TOL_W-1:0]   tol,
  input  sit_pkg::entry_t             head,
  input  logic                        head_valid,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_intersects
);

  typedef struct packed {
    logic                                      hit_x;
    logic [sit_pkg::LANES-1:0]                 coll;
    logic                                      use_tol;
    logic [sit_pkg::LANES-1:0][sit_pkg::SW-1:0] s;
    logic [sit_pkg::LANES-1:0][sit_pkg::SW-1:0] h;
  } carry_t;

  localparam int NS = sit_pkg::RW + 3;   // root stages plus entry, slack, output

  logic                        be;
  logic [NS-1:0]               vld_r;
  carry_t                      cy_r [sit_pkg::RW + 2];
  logic [sit_pkg::PW-1:0]      op_r [sit_pkg::RW + 1][2];
  logic [sit_pkg::PW-1:0]      rt_r [sit_pkg::RW + 1][2];
  logic [sit_pkg::SLW-1:0]     sl_r [2];
  logic                        out_intersects_r;
  logic                        hit_nxt;
  logic [sit_pkg::SW:0]        lo_sum;
  logic [sit_pkg::SW:0]        hi_sum;

  assign be             = !vld_r[NS-1] || !out_stall;
  assign pop            = head_valid && be;
  assign out_valid      = vld_r[NS-1];
  assign out_intersects = out_intersects_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (be) begin
      vld_r <= {vld_r[NS-2:0], pop};
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      cy_r[0].hit_x   <= head.hit_x;
      cy_r[0].coll    <= head.coll;
      cy_r[0].use_tol <= head.use_tol;
      cy_r[0].s       <= head.s;
      cy_r[0].h       <= head.h;
      for (int j = 0; j < 2; j++) begin
        op_r[0][j] <= head.l2[j];
        rt_r[0][j] <= '0;
      end
    end
  end

  // one result bit per stage, most significant first
  for (genvar g = 1; g <= sit_pkg::RW; g++) begin : g_root
    localparam logic [sit_pkg::PW-1:0] ONE = sit_pkg::PW'(1) << (2 * (sit_pkg::RW - g));
    logic [sit_pkg::PW:0]   trial [2];
    logic [sit_pkg::PW-1:0] op_nxt [2];
    logic [sit_pkg::PW-1:0] rt_nxt [2];

    always_comb begin
      for (int j = 0; j < 2; j++) begin
        trial[j] = {1'b0, rt_r[g-1][j]} + {1'b0, ONE};
        if ({1'b0, op_r[g-1][j]} >= trial[j]) begin
          op_nxt[j] = op_r[g-1][j] - trial[j][sit_pkg::PW-1:0];
          rt_nxt[j] = (rt_r[g-1][j] >> 1) + ONE;
        end else begin
          op_nxt[j] = op_r[g-1][j];
          rt_nxt[j] = rt_r[g-1][j] >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (be) begin
        cy_r[g] <= cy_r[g-1];
        for (int j = 0; j < 2; j++) begin
          op_r[g][j] <= op_nxt[j];
          rt_r[g][j] <= rt_nxt[j];
        end
      end
    end
  end

  // slack = tolerance * floor(sqrt(len^2)), zero for the exact test
  always_ff @(posedge clk) begin
    if (be) begin
      cy_r[sit_pkg::RW + 1] <= cy_r[sit_pkg::RW];
      for (int j = 0; j < 2; j++) begin
        if (cy_r[sit_pkg::RW].use_tol) begin
          sl_r[j] <= sit_pkg::SLW'(tol)
                   * sit_pkg::SLW'(rt_r[sit_pkg::RW][j][sit_pkg::RW-1:0]);
        end else begin
          sl_r[j] <= '0;
        end
      end
    end
  end

  // on-segment: s + slack >= 0 and (len^2 - s) + slack >= 0
  always_comb begin
    hit_nxt = cy_r[sit_pkg::RW + 1].hit_x;
    lo_sum  = '0;
    hi_sum  = '0;
    for (int i = 0; i < sit_pkg::LANES; i++) begin
      lo_sum = {cy_r[sit_pkg::RW + 1].s[i][sit_pkg::SW-1], cy_r[sit_pkg::RW + 1].s[i]}
             + {{(sit_pkg::SW + 1 - sit_pkg::SLW){1'b0}}, sl_r[i / 2]};
      hi_sum = {cy_r[sit_pkg::RW + 1].h[i][sit_pkg::SW-1], cy_r[sit_pkg::RW + 1].h[i]}
             + {{(sit_pkg::SW + 1 - sit_pkg::SLW){1'b0}}, sl_r[i / 2]};
      if (cy_r[sit_pkg::RW + 1].coll[i] && !lo_sum[sit_pkg::SW] && !hi_sum[sit_pkg::SW]) begin
        hit_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      out_intersects_r <= hit_nxt;
    end
  end

endmodule

@@ rtl/sit_checker.sv @@
// sit_checker: port-level checks for segment_intersection_test, bound to the
// top level. Depends on nothing but the top level's port names.
module sit_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_intersects
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_intersects))
    else $error("stalled result beat changed");

  // pipeline comes out of reset empty and open
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid && !in_stall)
    else $error("not empty after reset");

  // with the output register empty the back drains, so the input never stalls
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output register empty");

  // input stall only ever follows a pending output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && in_valid |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

endmodule

bind segment_intersection_test sit_checker u_sit_checker (.*);
